FILE: design/lfrq_pkg.sv
// Shared types and constants for the line framed ring queue.
// No dependencies; the interfaces and the front, back and top files use it by scoped names.
`timescale 1ns / 1ps

package lfrq_pkg;

  localparam int BYTE_W = 8;

  typedef logic [BYTE_W-1:0] byte_t;

  // Line terminators.
  localparam byte_t CODE_CR = 8'd13;
  localparam byte_t CODE_LF = 8'd10;

  // Input beat actions.
  localparam logic ACT_RECV = 1'b0;
  localparam logic ACT_POP  = 1'b1;

endpackage

FILE: design/lfrq_in_if.sv
// Input channel of the line framed ring queue: valid/ready plus payload.
// Depends on lfrq_pkg.
`timescale 1ns / 1ps

interface lfrq_in_if;
  logic            valid;
  logic            ready;
  logic            action;
  lfrq_pkg::byte_t byte_value;

  modport source (output valid, output action, output byte_value, input ready);
  modport sink   (input valid, input action, input byte_value, output ready);
endinterface

FILE: design/lfrq_out_if.sv
// Result channel of the line framed ring queue: valid/ready plus payload.
// Depends on lfrq_pkg.
`timescale 1ns / 1ps

interface lfrq_out_if;
  logic            valid;
  logic            ready;
  logic            line_present;
  lfrq_pkg::byte_t char_out;
  logic            last;

  modport source (output valid, output line_present, output char_out, output last,
                  input ready);
  modport sink   (input valid, input line_present, input char_out, input last,
                  output ready);
endinterface

FILE: design/lfrq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lfrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lfrq_cmd_queue.sv
// Two-entry queue carrying pop commands from the front part to the back part.
// No dependencies.
`timescale 1ns / 1ps

module lfrq_cmd_queue #(
  parameter int W = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] entry_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/lfrq_front.sv
// Front part: accepts input beats, assembles lines into the character RAM,
// keeps the ring pointers and issues pop commands. Depends on lfrq_pkg, lfrq_in_if.
`timescale 1ns / 1ps

module lfrq_front #(
  parameter int QUEUE_SLOTS = 6,
  parameter int LINE_BYTES  = 64
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  lfrq_in_if.sink                                         in_ch,
  input  logic                                            q_full,
  input  logic                                            back_busy,
  output logic                                            q_push,
  output logic                                            q_present,
  output logic [$clog2(QUEUE_SLOTS)-1:0]                  q_slot,
  output logic                                            char_we,
  output logic [$clog2(QUEUE_SLOTS*(LINE_BYTES-1))-1:0]   char_waddr,
  output lfrq_pkg::byte_t                                 char_wdata,
  output logic                                            len_we,
  output logic [$clog2(QUEUE_SLOTS)-1:0]                  len_waddr,
  output logic [$clog2(LINE_BYTES)-1:0]                   len_wdata
);

  localparam int LINE_CHARS = LINE_BYTES - 1;
  localparam int SW = $clog2(QUEUE_SLOTS);
  localparam int CW = $clog2(LINE_BYTES);
  localparam int AW = $clog2(QUEUE_SLOTS * LINE_CHARS);

  logic [CW-1:0] partial_r, partial_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic [SW-1:0] head_r, head_nxt;
  logic [SW-1:0] tail_r, tail_nxt;

  logic          is_pop, accept, is_term, line_full;
  logic [CW-1:0] pc, kc;
  logic [SW-1:0] head_inc, tail_inc;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SW'(QUEUE_SLOTS - 1)) ? '0 : s + SW'(1);
  endfunction

  assign is_pop       = (in_ch.action == lfrq_pkg::ACT_POP);
  // Pops only need room in the command queue; bytes wait until no pop is queued or being read.
  assign in_ch.ready  = is_pop ? !q_full : !back_busy;
  assign accept       = in_ch.valid && in_ch.ready;
  assign is_term      = (in_ch.byte_value == lfrq_pkg::CODE_CR) ||
                        (in_ch.byte_value == lfrq_pkg::CODE_LF);
  assign line_full    = (partial_r >= CW'(LINE_CHARS));
  assign pc           = line_full ? '0 : partial_r;
  assign kc           = line_full ? '0 : kept_r;
  assign head_inc     = next_slot(head_r);
  assign tail_inc     = next_slot(tail_r);

  assign q_slot     = tail_r;
  assign q_present  = (head_r != tail_r);
  assign char_waddr = AW'(AW'(head_r) * AW'(LINE_CHARS)) + AW'(pc);
  assign char_wdata = in_ch.byte_value;
  assign len_waddr  = head_r;
  assign len_wdata  = kept_r;

  always_comb begin
    partial_nxt = partial_r;
    kept_nxt    = kept_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    q_push      = 1'b0;
    char_we     = 1'b0;
    len_we      = 1'b0;
    if (accept && is_pop) begin
      q_push = 1'b1;
      if (q_present) begin
        tail_nxt = tail_inc;
      end
    end else if (accept && is_term) begin
      if (kept_r != '0) begin
        len_we   = 1'b1;
        head_nxt = head_inc;
        if (head_inc == tail_r) begin
          tail_nxt = tail_inc;
        end
      end
      partial_nxt = '0;
      kept_nxt    = '0;
    end else if (accept) begin
      kept_nxt = kc;
      if ((kc == pc) && (in_ch.byte_value != '0)) begin
        char_we  = 1'b1;
        kept_nxt = kc + CW'(1);
      end
      partial_nxt = pc + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      kept_r    <= '0;
      head_r    <= '0;
      tail_r    <= '0;
    end else begin
      partial_r <= partial_nxt;
      kept_r    <= kept_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
    end
  end

endmodule

FILE: design/lfrq_back.sv
// Back part: takes pop commands, reads the line length and characters from
// RAM and streams result beats through a two-entry output buffer.
// Depends on lfrq_pkg, lfrq_out_if.
`timescale 1ns / 1ps

module lfrq_back #(
  parameter int QUEUE_SLOTS = 6,
  parameter int LINE_BYTES  = 64
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            q_empty,
  input  logic [$clog2(QUEUE_SLOTS):0]                    q_data,
  output logic                                            q_pop,
  output logic                                            busy,
  output logic [$clog2(QUEUE_SLOTS)-1:0]                  len_raddr,
  input  logic [$clog2(LINE_BYTES)-1:0]                   len_rdata,
  output logic [$clog2(QUEUE_SLOTS*(LINE_BYTES-1))-1:0]   char_raddr,
  input  lfrq_pkg::byte_t                                 char_rdata,
  lfrq_out_if.source                                      out_ch
);

  localparam int LINE_CHARS = LINE_BYTES - 1;
  localparam int SW = $clog2(QUEUE_SLOTS);
  localparam int CW = $clog2(LINE_BYTES);
  localparam int AW = $clog2(QUEUE_SLOTS * LINE_CHARS);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_LEN  = 3'b010,
    B_STRM = 3'b100
  } back_state_t;

  typedef struct packed {
    logic            present;
    lfrq_pkg::byte_t ch;
    logic            last;
  } beat_t;

  back_state_t   state_r, state_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] base_r, base_nxt;

  // Read stage: a beat whose character arrives from the RAM this cycle.
  logic rd_v_r, rd_v_nxt;
  logic rd_present_r, rd_present_nxt;
  logic rd_last_r, rd_last_nxt;

  // Output buffer.
  beat_t      ob_r [2];
  logic       ob_wr_r, ob_rd_r;
  logic [1:0] ob_cnt_r;
  logic       ob_pop, credit, cmd_present, strm_last;
  beat_t      ob_in;

  assign cmd_present = q_data[SW];
  assign len_raddr   = q_data[SW-1:0];
  assign char_raddr  = base_r + AW'(idx_r);
  assign busy        = (state_r != B_IDLE) || !q_empty;
  assign strm_last   = ((idx_r + CW'(1)) == len_r);

  assign ob_pop  = out_ch.valid && out_ch.ready;
  // A read may start when the buffer cannot overflow once its data lands.
  assign credit  = (3'(ob_cnt_r) + 3'(rd_v_r)) < (3'd2 + 3'(ob_pop));

  assign out_ch.valid        = (ob_cnt_r != 2'd0);
  assign out_ch.line_present = ob_r[ob_rd_r].present;
  assign out_ch.char_out     = ob_r[ob_rd_r].ch;
  assign out_ch.last         = ob_r[ob_rd_r].last;

  assign ob_in.present = rd_present_r;
  assign ob_in.ch      = rd_present_r ? char_rdata : '0;
  assign ob_in.last    = rd_last_r;

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    base_nxt       = base_r;
    rd_v_nxt       = 1'b0;
    rd_present_nxt = rd_present_r;
    rd_last_nxt    = rd_last_r;
    q_pop          = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (cmd_present) begin
            q_pop     = 1'b1;
            slot_nxt  = q_data[SW-1:0];
            state_nxt = B_LEN;
          end else if (credit) begin
            q_pop          = 1'b1;
            rd_v_nxt       = 1'b1;
            rd_present_nxt = 1'b0;
            rd_last_nxt    = 1'b1;
          end
        end
      end
      B_LEN: begin
        len_nxt   = (len_rdata == '0) ? CW'(1) : len_rdata;
        idx_nxt   = '0;
        base_nxt  = AW'(AW'(slot_r) * AW'(LINE_CHARS));
        state_nxt = B_STRM;
      end
      B_STRM: begin
        if (credit) begin
          rd_v_nxt       = 1'b1;
          rd_present_nxt = 1'b1;
          rd_last_nxt    = strm_last;
          idx_nxt        = idx_r + CW'(1);
          if (strm_last) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      rd_v_r   <= 1'b0;
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      rd_v_r   <= rd_v_nxt;
      ob_wr_r  <= ob_wr_r ^ rd_v_r;
      ob_rd_r  <= ob_rd_r ^ ob_pop;
      ob_cnt_r <= ob_cnt_r + 2'(rd_v_r) - 2'(ob_pop);
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    len_r        <= len_nxt;
    idx_r        <= idx_nxt;
    base_r       <= base_nxt;
    rd_present_r <= rd_present_nxt;
    rd_last_r    <= rd_last_nxt;
    if (rd_v_r) begin
      ob_r[ob_wr_r] <= ob_in;
    end
  end

endmodule

FILE: design/line_framed_ring_queue.sv
// Line framed ring queue. A received byte gives no beat. A pop of a stored line goes
// through the command queue, the back reads its length, then streams its characters one
// per cycle while the output buffer has room (set by the character RAM read port); an empty
// pop answers with a single beat. Bytes are held off while a popped line is still being read.
// Reset (rst_n low, synchronous) empties the ring and the line being built; the RAMs
// keep their contents and need no clearing pass.
`timescale 1ns / 1ps

module line_framed_ring_queue #(
  parameter int QUEUE_SLOTS = 6,
  parameter int LINE_BYTES  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  lfrq_in_if.sink     in_ch,
  lfrq_out_if.source  out_ch
);

  localparam int LINE_CHARS = LINE_BYTES - 1;
  localparam int SW = $clog2(QUEUE_SLOTS);
  localparam int CW = $clog2(LINE_BYTES);
  localparam int CHAR_DEPTH = QUEUE_SLOTS * LINE_CHARS;
  localparam int AW = $clog2(CHAR_DEPTH);

  // Pop command from front to back: whether a line was found, and its slot.
  logic          q_push, q_pop, q_full, q_empty;
  logic          q_present;
  logic [SW-1:0] q_slot;
  logic [SW:0]   q_wdata, q_rdata;
  logic          back_busy;

  // Character store: one row of LINE_CHARS bytes per slot. The row at the
  // head of the ring is also where the line being received is assembled.
  logic            char_we;
  logic [AW-1:0]   char_waddr, char_raddr;
  lfrq_pkg::byte_t char_wdata, char_rdata;

  // Kept length of each stored line.
  logic          len_we;
  logic [SW-1:0] len_waddr, len_raddr;
  logic [CW-1:0] len_wdata, len_rdata;

  assign q_wdata = {q_present, q_slot};

  // The front owns the ring pointers, so the order of pops and line commits
  // is settled at acceptance. The back only reads the RAMs, and the front
  // holds off bytes while any pop is queued or streaming, so a slot that is
  // being read out cannot be overwritten under it.
  lfrq_front #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .LINE_BYTES  (LINE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .back_busy  (back_busy),
    .q_push     (q_push),
    .q_present  (q_present),
    .q_slot     (q_slot),
    .char_we    (char_we),
    .char_waddr (char_waddr),
    .char_wdata (char_wdata),
    .len_we     (len_we),
    .len_waddr  (len_waddr),
    .len_wdata  (len_wdata)
  );

  lfrq_cmd_queue #(
    .W (SW + 1)
  ) u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  lfrq_ram #(
    .WIDTH (lfrq_pkg::BYTE_W),
    .DEPTH (CHAR_DEPTH)
  ) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (char_waddr),
    .wdata (char_wdata),
    .raddr (char_raddr),
    .rdata (char_rdata)
  );

  lfrq_ram #(
    .WIDTH (CW),
    .DEPTH (QUEUE_SLOTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  // The back reads the length, then streams characters into a two-beat
  // output buffer, so a stalled sink holds off new pops only once the
  // command queue is full.
  lfrq_back #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .LINE_BYTES  (LINE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .busy       (back_busy),
    .len_raddr  (len_raddr),
    .len_rdata  (len_rdata),
    .char_raddr (char_raddr),
    .char_rdata (char_rdata),
    .out_ch     (out_ch)
  );

endmodule
